[hdl/rational_arithmetic_unit_assert.svh]
// assertion macros shared by the checker
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RAU_CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rational unit check failed");

// next-cycle implication, sampled on clk, off while in reset
`define RAU_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rational unit check failed");

`endif

[hdl/rau_pkg.sv]
package rau_pkg;

	localparam int WIDTH = 32;
	localparam int EW = (WIDTH > 32) ? 32 : WIDTH;
	localparam int DW = 64;
	localparam logic [DW-1:0] LIMIT = 64'd1 << (EW - 1);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_OVF     = 2'd2;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         order;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_GCD_AB,
		CMD_DIV_FA,
		CMD_DIV_FB,
		CMD_MUL_XA,
		CMD_MUL_YB,
		CMD_MUL_L,
		CMD_SUM,
		CMD_MUL_NUM,
		CMD_MUL_DEN,
		CMD_GCD_RED,
		CMD_DIV_NUM,
		CMD_DIV_DEN,
		CMD_EMIT_ERR,
		CMD_EMIT_CMP,
		CMD_EMIT_RES
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t  code;
		logic       start;
		logic [1:0] err;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       den_zero;
		logic       bnum_zero;
		logic       gcd_done;
		logic       div_done;
	} dp_stat_t;

endpackage

[hdl/rau_gcd.sv]
module rau_gcd import rau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] x,
	input  logic [DW-1:0] y,
	output logic          done,
	output logic [DW-1:0] g
);

	logic [DW-1:0] u_q, v_q, g_q;
	logic [5:0]    k_q;
	logic          run_q, done_q;
	logic          fin;

	// binary gcd, one shift or subtract per cycle
	assign fin = (u_q == '0) || (v_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && fin) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= x;
			v_q <= y;
			k_q <= '0;
		end else if (run_q) begin
			priority if (u_q == '0) begin
				g_q <= v_q << k_q;
			end else if (v_q == '0) begin
				g_q <= u_q << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign done = done_q;
	assign g = g_q;

endmodule

[hdl/rau_div.sv]
module rau_div import rau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo
);

	logic [DW-1:0] rem_q, quo_q, dvs_q;
	logic [5:0]    cnt_q;
	logic          run_q, done_q;
	logic [DW:0]   trial, diff;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

[hdl/rau_dp.sv]
module rau_dp import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output rsp_t     rsp
);

	logic [2:0]         op_q;
	logic signed [31:0] an_q, bn_q;
	logic [30:0]        ad_q, bd_q;
	logic [31:0]        fa_q, fb_q;
	logic [DW-1:0]      x_mag_q, y_mag_q, d_mag_q, g_q;
	logic               x_neg_q, y_neg_q;
	rsp_t               rsp_q;

	logic [31:0]   an_mag, bn_mag, ad32, bd32, mul_a, mul_b;
	logic [DW-1:0] prod;
	logic          gcd_start, div_start, gcd_done, div_done;
	logic [DW-1:0] gcd_x, gcd_y, gcd_g, div_n, div_q;
	logic [DW:0]   sx, sy, s, s_mag;
	logic          neg, ovf;
	logic [31:0]   num_out;

	assign an_mag = an_q[31] ? (~an_q + 32'd1) : an_q;
	assign bn_mag = bn_q[31] ? (~bn_q + 32'd1) : bn_q;
	assign ad32 = {1'b0, ad_q};
	assign bd32 = {1'b0, bd_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.code)
			CMD_MUL_XA: begin
				mul_a = an_mag;
				mul_b = fa_q;
			end
			CMD_MUL_YB: begin
				mul_a = bn_mag;
				mul_b = fb_q;
			end
			CMD_MUL_L: begin
				mul_a = fb_q;
				mul_b = bd32;
			end
			CMD_MUL_NUM: begin
				mul_a = an_mag;
				mul_b = (op_q == OP_MUL) ? bn_mag : bd32;
			end
			CMD_MUL_DEN: begin
				mul_a = ad32;
				mul_b = (op_q == OP_MUL) ? bd32 : bn_mag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {32'd0, mul_a} * {32'd0, mul_b};

	assign gcd_start = cmd.start && (cmd.code == CMD_GCD_AB || cmd.code == CMD_GCD_RED);
	assign gcd_x = (cmd.code == CMD_GCD_AB) ? {33'd0, ad_q} : x_mag_q;
	assign gcd_y = (cmd.code == CMD_GCD_AB) ? {33'd0, bd_q} : d_mag_q;

	assign div_start = cmd.start && (cmd.code == CMD_DIV_FA || cmd.code == CMD_DIV_FB ||
		cmd.code == CMD_DIV_NUM || cmd.code == CMD_DIV_DEN);

	always_comb begin
		unique case (cmd.code)
			CMD_DIV_FA:  div_n = {33'd0, bd_q};
			CMD_DIV_FB:  div_n = {33'd0, ad_q};
			CMD_DIV_NUM: div_n = x_mag_q;
			default:     div_n = d_mag_q;
		endcase
	end

	rau_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.x      (gcd_x),
		.y      (gcd_y),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (g_q),
		.done     (div_done),
		.quo      (div_q)
	);

	// signed views of the two magnitudes
	assign sx = x_neg_q ? (~{1'b0, x_mag_q} + 65'd1) : {1'b0, x_mag_q};
	assign sy = y_neg_q ? (~{1'b0, y_mag_q} + 65'd1) : {1'b0, y_mag_q};
	assign s = sx + sy;
	assign s_mag = s[DW] ? (~s + 65'd1) : s;

	assign neg = x_neg_q && (x_mag_q != '0);
	assign ovf = (d_mag_q > LIMIT - 64'd1) ||
		(neg ? (x_mag_q > LIMIT) : (x_mag_q > LIMIT - 64'd1));
	assign num_out = neg ? (~x_mag_q[31:0] + 32'd1) : x_mag_q[31:0];

	always_ff @(posedge clk) begin
		unique case (cmd.code)
			CMD_LOAD: begin
				op_q <= req.op;
				an_q <= req.a_num;
				ad_q <= req.a_den;
				bn_q <= req.b_num;
				bd_q <= req.b_den;
			end
			CMD_GCD_AB, CMD_GCD_RED: begin
				if (gcd_done) begin
					g_q <= gcd_g;
				end
			end
			CMD_DIV_FA: begin
				if (div_done) begin
					fa_q <= div_q[31:0];
				end
			end
			CMD_DIV_FB: begin
				if (div_done) begin
					fb_q <= div_q[31:0];
				end
			end
			CMD_DIV_NUM: begin
				if (div_done) begin
					x_mag_q <= div_q;
				end
			end
			CMD_DIV_DEN: begin
				if (div_done) begin
					d_mag_q <= div_q;
				end
			end
			CMD_MUL_XA: begin
				x_mag_q <= prod;
				x_neg_q <= an_q[31];
			end
			CMD_MUL_YB: begin
				y_mag_q <= prod;
				y_neg_q <= bn_q[31] ^ (op_q == OP_SUB);
			end
			CMD_MUL_L: begin
				d_mag_q <= prod;
			end
			CMD_SUM: begin
				x_mag_q <= s_mag[DW-1:0];
				x_neg_q <= s[DW];
			end
			CMD_MUL_NUM: begin
				x_mag_q <= prod;
				x_neg_q <= an_q[31] ^ ((op_q != OP_CMP) && bn_q[31]);
			end
			CMD_MUL_DEN: begin
				d_mag_q <= prod;
				y_mag_q <= prod;
				y_neg_q <= bn_q[31];
			end
			CMD_EMIT_ERR: begin
				rsp_q.res_num <= '0;
				rsp_q.res_den <= 31'd1;
				rsp_q.order <= ORD_LESS;
				rsp_q.status <= cmd.err;
			end
			CMD_EMIT_CMP: begin
				rsp_q.res_num <= '0;
				rsp_q.res_den <= 31'd1;
				rsp_q.status <= ST_OK;
				if ($signed(sx) < $signed(sy)) begin
					rsp_q.order <= ORD_LESS;
				end else if (sx == sy) begin
					rsp_q.order <= ORD_EQUAL;
				end else begin
					rsp_q.order <= ORD_GREATER;
				end
			end
			CMD_EMIT_RES: begin
				rsp_q.order <= ORD_LESS;
				if (ovf) begin
					rsp_q.res_num <= '0;
					rsp_q.res_den <= 31'd1;
					rsp_q.status <= ST_OVF;
				end else begin
					rsp_q.res_num <= num_out;
					rsp_q.res_den <= d_mag_q[30:0];
					rsp_q.status <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.op = op_q;
	assign stat.den_zero = (ad_q == '0) || (bd_q == '0);
	assign stat.bnum_zero = (bn_q == '0);
	assign stat.gcd_done = gcd_done;
	assign stat.div_done = div_done;
	assign rsp = rsp_q;

endmodule

[hdl/rau_ctrl.sv]
module rau_ctrl import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_GCD_AB,
		S_DIV_FA,
		S_DIV_FB,
		S_MUL_XA,
		S_MUL_YB,
		S_MUL_L,
		S_SUM,
		S_MUL_NUM,
		S_MUL_DEN,
		S_GCD_RED,
		S_DIV_NUM,
		S_DIV_DEN,
		S_EMIT
	} state_t;

	state_t    state_q;
	logic      busy_q, rsp_valid_q;
	cmd_code_t emit_code_q;
	logic [1:0] err_q;
	logic      unit_state, unit_done, emit_fire;

	assign unit_state = (state_q == S_GCD_AB) || (state_q == S_GCD_RED) ||
		(state_q == S_DIV_FA) || (state_q == S_DIV_FB) ||
		(state_q == S_DIV_NUM) || (state_q == S_DIV_DEN);
	assign unit_done = ((state_q == S_GCD_AB) || (state_q == S_GCD_RED)) ?
		stat.gcd_done : stat.div_done;
	assign emit_fire = (state_q == S_EMIT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		cmd.start = unit_state && !busy_q;
		cmd.err = err_q;
		unique case (state_q)
			S_IDLE:    cmd.code = req_valid ? CMD_LOAD : CMD_NONE;
			S_CHECK:   cmd.code = CMD_NONE;
			S_GCD_AB:  cmd.code = CMD_GCD_AB;
			S_DIV_FA:  cmd.code = CMD_DIV_FA;
			S_DIV_FB:  cmd.code = CMD_DIV_FB;
			S_MUL_XA:  cmd.code = CMD_MUL_XA;
			S_MUL_YB:  cmd.code = CMD_MUL_YB;
			S_MUL_L:   cmd.code = CMD_MUL_L;
			S_SUM:     cmd.code = CMD_SUM;
			S_MUL_NUM: cmd.code = CMD_MUL_NUM;
			S_MUL_DEN: cmd.code = CMD_MUL_DEN;
			S_GCD_RED: cmd.code = CMD_GCD_RED;
			S_DIV_NUM: cmd.code = CMD_DIV_NUM;
			S_DIV_DEN: cmd.code = CMD_DIV_DEN;
			S_EMIT:    cmd.code = emit_fire ? emit_code_q : CMD_NONE;
			default:   cmd.code = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			emit_code_q <= CMD_EMIT_ERR;
			err_q <= ST_OK;
		end else begin
			rsp_valid_q <= emit_fire || (rsp_valid_q && rsp_stall);
			if (unit_state) begin
				busy_q <= !unit_done;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					err_q <= ST_OK;
					priority if (stat.op > OP_CMP) begin
						emit_code_q <= CMD_EMIT_ERR;
						state_q <= S_EMIT;
					end else if (stat.den_zero ||
						(stat.op == OP_DIV && stat.bnum_zero)) begin
						emit_code_q <= CMD_EMIT_ERR;
						err_q <= ST_DIVZERO;
						state_q <= S_EMIT;
					end else if (stat.op == OP_ADD || stat.op == OP_SUB) begin
						state_q <= S_GCD_AB;
					end else begin
						state_q <= S_MUL_NUM;
					end
				end
				S_GCD_AB: if (unit_done) state_q <= S_DIV_FA;
				S_DIV_FA: if (unit_done) state_q <= S_DIV_FB;
				S_DIV_FB: if (unit_done) state_q <= S_MUL_XA;
				S_MUL_XA: state_q <= S_MUL_YB;
				S_MUL_YB: state_q <= S_MUL_L;
				S_MUL_L: state_q <= S_SUM;
				S_SUM: state_q <= S_GCD_RED;
				S_MUL_NUM: state_q <= S_MUL_DEN;
				S_MUL_DEN: begin
					if (stat.op == OP_CMP) begin
						emit_code_q <= CMD_EMIT_CMP;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_GCD_RED;
					end
				end
				S_GCD_RED: if (unit_done) state_q <= S_DIV_NUM;
				S_DIV_NUM: if (unit_done) state_q <= S_DIV_DEN;
				S_DIV_DEN: begin
					if (unit_done) begin
						emit_code_q <= CMD_EMIT_RES;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (emit_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

[hdl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares two fractions and
// returns the reduced result with a positive denominator, or an error status for a zero
// denominator, division by zero or a result that does not fit. One transaction is worked on
// at a time; the next is taken while the previous result still waits on the output. Compare
// takes two multiplies and a signed comparison and returns only the order. Multiply and divide
// take two multiplies, a binary gcd (one shift or subtract per cycle) and two serial divides.
// Add and subtract instead take a gcd of the denominators, two divides, three multiplies and a
// sum, then the same gcd and two divides.
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[hdl/rau_checker.sv]
`include "rational_arithmetic_unit_assert.svh"

module rau_checker import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	`RAU_CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`RAU_CHK_SAME(a_err_zero, rsp_valid && rsp.status != ST_OK, rsp.res_num == 0 && rsp.res_den == 31'd1 && rsp.order == ORD_LESS)
	`RAU_CHK_SAME(a_den_pos, rsp_valid, rsp.res_den != '0)
	`RAU_CHK_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
